/* hw/rtl/cdq_pkg.sv */
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int DATA_W   = 32;
    localparam int CAP_W    = 11;
    localparam int CNT_W    = 11;

    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cdq_cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } cdq_status_t;

    typedef struct packed {
        cdq_cmd_t                 cmd;
        logic signed [DATA_W-1:0] push_value;
    } cdq_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_data;
        cdq_status_t              status;
        logic [CNT_W-1:0]         entry_count;
    } cdq_rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } cdq_mem_ctl_t;

endpackage

/* hw/rtl/cdq_ram.sv */
// Ring store: single-port synchronous memory with registered read data.
module cdq_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          aclk,
    input  cdq_pkg::cdq_mem_ctl_t         mem_ctl,
    input  logic [AW-1:0]                 mem_addr,
    input  logic signed [cdq_pkg::DATA_W-1:0] mem_wdata,
    output logic signed [cdq_pkg::DATA_W-1:0] mem_rdata
);
    import cdq_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_ctl.rd_en) begin
            rdata_reg <= mem[mem_addr];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

/* hw/rtl/cdq_ctrl.sv */
// Deque control: pointers, entry count, capacity, store access and result register.
module cdq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int CW    = 11
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  cdq_pkg::cdq_req_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output cdq_pkg::cdq_rsp_t             m_data,
    output cdq_pkg::cdq_mem_ctl_t         mem_ctl,
    output logic [AW-1:0]                 mem_addr,
    output logic signed [cdq_pkg::DATA_W-1:0] mem_wdata,
    input  logic signed [cdq_pkg::DATA_W-1:0] mem_rdata
);
    import cdq_pkg::*;

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    cap_reg, cap_next;
    logic             valid_reg, valid_next;
    cdq_status_t      status_reg, status_next;
    logic [CNT_W-1:0] ecount_reg, ecount_next;
    logic             rd_sel_reg, rd_sel_next;

    logic             accept;
    logic             cfg_accept;
    logic             is_full;
    logic             is_empty;
    logic [CW-1:0]    head_plus, tail_plus;
    logic [AW-1:0]    head_inc, head_dec, tail_inc, tail_dec;
    logic [AW-1:0]    cap_last;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid;
    assign s_ready    = !valid_reg || m_ready;
    assign accept     = s_valid && s_ready;

    assign is_full   = count_reg >= cap_reg;
    assign is_empty  = count_reg == '0;
    assign cap_last  = AW'(cap_reg - CW'(1));
    assign head_plus = CW'(head_reg) + CW'(1);
    assign tail_plus = CW'(tail_reg) + CW'(1);
    assign head_inc  = (head_plus >= cap_reg) ? '0 : AW'(head_plus);
    assign tail_inc  = (tail_plus >= cap_reg) ? '0 : AW'(tail_plus);
    assign head_dec  = (head_reg == '0) ? cap_last : head_reg - AW'(1);
    assign tail_dec  = (tail_reg == '0) ? cap_last : tail_reg - AW'(1);

    always_comb begin
        if (cfg_data == '0) begin
            cap_next = CW'(1);
        end else if (32'(cfg_data) > 32'(DEPTH)) begin
            cap_next = CW'(DEPTH);
        end else begin
            cap_next = CW'(cfg_data);
        end
    end

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STATUS_DONE;
        rd_sel_next = 1'b0;
        mem_ctl     = '0;
        mem_addr    = head_reg;
        mem_wdata   = s_data.push_value;
        unique case (s_data.cmd)
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    head_next     = head_dec;
                    mem_addr      = head_dec;
                    mem_ctl.wr_en = accept;
                    count_next    = count_reg + CW'(1);
                end
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    status_next = STATUS_FULL;
                end else begin
                    tail_next     = tail_inc;
                    mem_addr      = tail_reg;
                    mem_ctl.wr_en = accept;
                    count_next    = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    head_next     = head_inc;
                    mem_addr      = head_reg;
                    mem_ctl.rd_en = accept;
                    rd_sel_next   = 1'b1;
                    count_next    = count_reg - CW'(1);
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    tail_next     = tail_dec;
                    mem_addr      = tail_dec;
                    mem_ctl.rd_en = accept;
                    rd_sel_next   = 1'b1;
                    count_next    = count_reg - CW'(1);
                end
            end
            default: begin
                status_next = STATUS_DONE;
            end
        endcase
        ecount_next = CNT_W'(count_next);
    end

    assign valid_next = accept || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CW'(DEPTH);
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_accept) begin
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
                cap_reg   <= cap_next;
            end else if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            ecount_reg <= ecount_next;
            rd_sel_reg <= rd_sel_next;
        end
    end

    always_comb begin
        m_valid            = valid_reg;
        m_data.status      = status_reg;
        m_data.entry_count = ecount_reg;
        if (rd_sel_reg) begin
            m_data.pop_data = mem_rdata;
        end else if (status_reg == STATUS_EMPTY) begin
            m_data.pop_data = WORD_MIN;
        end else begin
            m_data.pop_data = '0;
        end
    end

endmodule

/* hw/rtl/circular_deque_top.sv */
// Circular deque top level: control and ring store.
// Results are registered: a result is offered in the cycle after its request is taken.
// Throughput: one request per cycle while m_ready is high; the result register holds while m_ready is low,
// and the store's single port serves the one read or write of each request.
// Reset clears head, tail and count and sets capacity to DEPTH; store contents
// are not cleared. A capacity write empties the deque.
module circular_deque_top #(
    parameter int DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cdq_pkg::cdq_req_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cdq_pkg::cdq_rsp_t         m_data
);
    import cdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdq_mem_ctl_t             mem_ctl;
    logic [AW-1:0]            mem_addr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic signed [DATA_W-1:0] mem_rdata;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    cdq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk      (aclk),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

endmodule
